// ----- hw/rtl/mllc_pkg.sv -----
// Shared types and constants for the least-likely-channel predictor.
`timescale 1ns / 1ps
package mllc_pkg;

    // Stored pick width (channel numbered from 1, zero before any recompute)
    localparam int PICK_W = 3;
    // Widest channel index over the supported channel counts
    localparam int MAX_CH_W = 4;

    // Stream beat widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // Item kinds carried on the input tuser bit
    localparam logic MODE_RECORD    = 1'b0;
    localparam logic MODE_RECOMPUTE = 1'b1;

    // Query level codes
    localparam logic [1:0] LVL_ONE_STEP = 2'd1;
    localparam logic [1:0] LVL_TWO_STEP = 2'd2;

    // Pick write from the scan engine to the pick tables
    typedef struct packed {
        logic                en;
        logic                done;
        logic [MAX_CH_W-1:0] row;
        logic [PICK_W-1:0]   one_step;
        logic [PICK_W-1:0]   two_step;
    } t_pick_wr;

endpackage

// ----- hw/rtl/mllc_count_mem.sv -----
// Transition counter memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module mllc_count_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DW-1:0]            o_rdata_a,
    output logic [DW-1:0]            o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;
    logic r_va;
    logic r_vb;

    // Write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    // Entry valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_va <= r_valid[i_raddr_a];
            r_vb <= r_valid[i_raddr_b];
        end
    end

    assign o_rdata_a = r_va ? r_rd_a : '0;
    assign o_rdata_b = r_vb ? r_rd_b : '0;

endmodule

// ----- hw/rtl/mllc_scan.sv -----
// Recompute engine: walks rows, candidates and path terms through one MAC pipeline.
`timescale 1ns / 1ps
module mllc_scan #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [COUNT_WIDTH-1:0]                i_total,
    output logic [$clog2(NUM_CHANNELS*NUM_CHANNELS)-1:0] o_addr_a,
    output logic [$clog2(NUM_CHANNELS*NUM_CHANNELS)-1:0] o_addr_b,
    input  logic [COUNT_WIDTH-1:0]                i_rd_a,
    input  logic [COUNT_WIDTH-1:0]                i_rd_b,
    output mllc_pkg::t_pick_wr                    o_pick
);

    localparam int CH_W  = $clog2(NUM_CHANNELS);
    localparam int AW    = $clog2(NUM_CHANNELS * NUM_CHANNELS);
    localparam int ACC_W = 2 * COUNT_WIDTH;

    typedef struct packed {
        logic            first_k;
        logic            last_k;
        logic            first_j;
        logic            last_j;
        logic            last_i;
        logic            k_eq_j;
        logic [CH_W-1:0] i;
        logic [CH_W-1:0] j;
    } t_tag;

    logic            r_run;
    logic [CH_W-1:0] r_i;
    logic [CH_W-1:0] r_j;
    logic [CH_W-1:0] r_k;
    logic [CH_W:0]   jp1;
    logic [CH_W:0]   jn;
    t_tag            tag0;

    logic             r_v1, r_v2, r_v3;
    t_tag             r_t1, r_t2, r_t3;
    logic [ACC_W-1:0] prod;
    logic [ACC_W-1:0] r_prod;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_tot_sq;
    logic [COUNT_WIDTH-1:0] r_c;
    logic [COUNT_WIDTH-1:0] r_c3;

    logic [COUNT_WIDTH-1:0] r_best1;
    logic [ACC_W-1:0]       r_best2;
    logic [CH_W-1:0]        r_pick1;
    logic [CH_W-1:0]        r_pick2;
    logic [COUNT_WIDTH-1:0] base1;
    logic [ACC_W-1:0]       base2;
    logic [CH_W-1:0]        pbase1;
    logic [CH_W-1:0]        pbase2;
    logic                   take1;
    logic                   take2;
    logic [CH_W-1:0]        fin_pick1;
    logic [CH_W-1:0]        fin_pick2;
    logic                   row_end;
    mllc_pkg::t_pick_wr     r_pick_wr;

    // Next candidate column, skipping the diagonal
    always_comb begin
        jp1 = {1'b0, r_j} + 1'b1;
        jn  = (jp1 == {1'b0, r_i}) ? jp1 + 1'b1 : jp1;
    end

    // Tag of the term issued this cycle
    always_comb begin
        tag0.first_k = (r_k == '0);
        tag0.last_k  = (r_k == CH_W'(NUM_CHANNELS - 1));
        tag0.first_j = (r_i == '0) ? (r_j == CH_W'(1)) : (r_j == '0);
        tag0.last_j  = (jn >= (CH_W + 1)'(NUM_CHANNELS));
        tag0.last_i  = (r_i == CH_W'(NUM_CHANNELS - 1));
        tag0.k_eq_j  = (r_k == r_j);
        tag0.i       = r_i;
        tag0.j       = r_j;
    end

    // Read count[i][k] and count[k][j]
    assign o_addr_a = AW'(int'(r_i) * NUM_CHANNELS + int'(r_k));
    assign o_addr_b = AW'(int'(r_k) * NUM_CHANNELS + int'(r_j));

    // Issue sequencer: k innermost, then j, then i
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_i   <= '0;
            r_j   <= CH_W'(1);
            r_k   <= '0;
        end else if (r_run) begin
            if (!tag0.last_k) begin
                r_k <= r_k + 1'b1;
            end else if (!tag0.last_j) begin
                r_k <= '0;
                r_j <= jn[CH_W-1:0];
            end else if (!tag0.last_i) begin
                r_k <= '0;
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    assign prod = i_rd_a * i_rd_b;

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= r_run;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Multiply, accumulate, and hold the one-step count of the candidate
    always_ff @(posedge i_clk) begin
        r_t1 <= tag0;
        r_t2 <= r_t1;
        r_t3 <= r_t2;
        r_prod <= prod;
        if (i_start) begin
            r_tot_sq <= i_total * i_total;
        end
        if (r_v1 && r_t1.k_eq_j) begin
            r_c <= i_rd_a;
        end
        if (r_v2) begin
            r_acc <= r_t2.first_k ? r_prod : r_acc + r_prod;
        end
        if (r_v2 && r_t2.last_k) begin
            r_c3 <= r_c;
        end
    end

    // Compare finished candidate against the running minimum of its row
    always_comb begin
        base1     = r_t3.first_j ? i_total  : r_best1;
        base2     = r_t3.first_j ? r_tot_sq : r_best2;
        pbase1    = r_t3.first_j ? '0 : r_pick1;
        pbase2    = r_t3.first_j ? '0 : r_pick2;
        take1     = (r_c3 < base1);
        take2     = (r_acc < base2);
        fin_pick1 = take1 ? r_t3.j : pbase1;
        fin_pick2 = take2 ? r_t3.j : pbase2;
        row_end   = r_v3 && r_t3.last_k && r_t3.last_j;
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && r_t3.last_k) begin
            r_best1 <= take1 ? r_c3  : base1;
            r_best2 <= take2 ? r_acc : base2;
            r_pick1 <= fin_pick1;
            r_pick2 <= fin_pick2;
        end
    end

    // Emit the row's picks, numbered from 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_wr.en   <= 1'b0;
            r_pick_wr.done <= 1'b0;
        end else begin
            r_pick_wr.en   <= row_end;
            r_pick_wr.done <= row_end && r_t3.last_i;
        end
        r_pick_wr.row      <= mllc_pkg::MAX_CH_W'(r_t3.i);
        r_pick_wr.one_step <= mllc_pkg::PICK_W'(int'(fin_pick1) + 1);
        r_pick_wr.two_step <= mllc_pkg::PICK_W'(int'(fin_pick2) + 1);
    end

    assign o_pick = r_pick_wr;

endmodule

// ----- hw/rtl/markov_least_likely_channel_core.sv -----
// Least-likely-channel predictor top: item sequencer, totals, pick tables, result beat.
//
// Input stream (s_axis): tuser selects the item kind, 0 records the transition
// prev_channel -> next_channel_idx, 1 recomputes the pick tables. Every item also
// carries a query (channel numbered from 1, level 1 or 2) and returns exactly one
// result beat on m_axis: the stored pick for that query and the saturation flag.
// A record item reads the counter from memory in the accept cycle and writes it back
// incremented in the next, when the result is loaded if the output register is free.
// A recompute item issues NUM_CHANNELS*NUM_CHANNELS*(NUM_CHANNELS-1) terms, one
// multiply-accumulate per cycle through the counter memory's two read ports, and
// then drains the MAC and compare pipeline.
// The block takes one item at a time; it accepts the next item while a result
// still waits in the output register, and holds in its final step while the
// receiver stalls. Reset clears all counters (per-entry valid bits, no clearing
// pass), the total and both pick tables; picks read 0 until the first recompute.
// Once the total reaches its maximum, record items change nothing.
`timescale 1ns / 1ps
module markov_least_likely_channel_core #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // prev_channel[1:0], next_channel_idx[3:2], query_channel[6:4], query_level[8:7]
    input  logic [mllc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // suggested_channel[2:0], saturated[3]
    output logic [mllc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int AW   = $clog2(NUM_CHANNELS * NUM_CHANNELS);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WB,
        ST_RECOMP,
        ST_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [mllc_pkg::PICK_W-1:0] r_out_sugg, n_out_sugg;
    logic   r_out_sat, n_out_sat;

    logic [1:0] in_prev;
    logic [1:0] in_next;
    logic [2:0] in_qch;
    logic [1:0] in_qlv;
    logic       in_acc;
    logic       in_rec_ok;
    logic [AW-1:0] in_addr;

    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] n_total;
    logic                   r_rec_ok;
    logic [AW-1:0]          r_waddr;
    logic [2:0]             r_qch;
    logic [1:0]             r_qlv;
    logic [mllc_pkg::PICK_W-1:0] r_one [NUM_CHANNELS];
    logic [mllc_pkg::PICK_W-1:0] r_two [NUM_CHANNELS];

    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr_a;
    logic [COUNT_WIDTH-1:0] mem_rd_a;
    logic [COUNT_WIDTH-1:0] mem_rd_b;
    logic [AW-1:0]          scan_addr_a;
    logic [AW-1:0]          scan_addr_b;
    logic                   scan_start;
    mllc_pkg::t_pick_wr     pick_wr;

    logic                   q_ok;
    logic [CH_W-1:0]        q_idx;
    logic [mllc_pkg::PICK_W-1:0] answer;
    logic                   out_free;
    logic                   load;

    // Unpack the input beat
    assign in_prev = s_axis_tdata[1:0];
    assign in_next = s_axis_tdata[3:2];
    assign in_qch  = s_axis_tdata[6:4];
    assign in_qlv  = s_axis_tdata[8:7];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign scan_start    = in_acc && (s_axis_tuser == mllc_pkg::MODE_RECOMPUTE);
    assign in_addr       = AW'(int'(in_prev) * NUM_CHANNELS + int'(in_next));
    assign in_rec_ok     = (s_axis_tuser == mllc_pkg::MODE_RECORD) &&
                           (int'(in_prev) < NUM_CHANNELS) &&
                           (int'(in_next) < NUM_CHANNELS) && (r_total != CNT_MAX);

    // Counter memory ports: scan owns the reads during a recompute
    assign mem_raddr_a = (r_state == ST_RECOMP) ? scan_addr_a : in_addr;
    assign mem_we      = (r_state == ST_WB) && r_rec_ok;
    assign mem_wdata   = mem_rd_a + 1'b1;
    assign n_total     = r_total + COUNT_WIDTH'(mem_we);

    mllc_count_mem #(
        .DEPTH (NUM_CHANNELS * NUM_CHANNELS),
        .DW    (COUNT_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (mem_we),
        .i_waddr   (r_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (scan_addr_b),
        .o_rdata_a (mem_rd_a),
        .o_rdata_b (mem_rd_b)
    );

    mllc_scan #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_total  (r_total),
        .o_addr_a (scan_addr_a),
        .o_addr_b (scan_addr_b),
        .i_rd_a   (mem_rd_a),
        .i_rd_b   (mem_rd_b),
        .o_pick   (pick_wr)
    );

    // Look up the stored pick for the query
    always_comb begin
        q_ok   = (r_qch != '0) && (int'(r_qch) <= NUM_CHANNELS);
        q_idx  = CH_W'(int'(r_qch) - 1);
        answer = '0;
        if (q_ok) begin
            case (r_qlv)
                mllc_pkg::LVL_ONE_STEP: answer = r_one[q_idx];
                mllc_pkg::LVL_TWO_STEP: answer = r_two[q_idx];
                default:                answer = '0;
            endcase
        end
    end

    // Sequencer next state and result load
    always_comb begin
        out_free    = !r_out_valid || m_axis_tready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_sugg  = r_out_sugg;
        n_out_sat   = r_out_sat;
        load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (s_axis_tuser == mllc_pkg::MODE_RECOMPUTE) ? ST_RECOMP : ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RECOMP: begin
                if (pick_wr.done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (load) begin
            n_out_valid = 1'b1;
            n_out_sugg  = answer;
            n_out_sat   = (n_total == CNT_MAX);
        end
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out_sugg <= n_out_sugg;
        r_out_sat  <= n_out_sat;
    end

    // Total counter and pick tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                r_one[n] <= '0;
                r_two[n] <= '0;
            end
        end else begin
            r_total <= n_total;
            if (pick_wr.en) begin
                r_one[pick_wr.row[CH_W-1:0]] <= pick_wr.one_step;
                r_two[pick_wr.row[CH_W-1:0]] <= pick_wr.two_step;
            end
        end
    end

    // Hold the accepted item's query and write target
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rec_ok <= in_rec_ok;
            r_waddr  <= in_addr;
            r_qch    <= in_qch;
            r_qlv    <= in_qlv;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mllc_pkg::OUT_TDATA_W - mllc_pkg::PICK_W - 1){1'b0}},
                            r_out_sat, r_out_sugg};

    // The total only grows between resets
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("total counter decreased");

    // A saturated total stays saturated
    a_total_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && ($past(r_total) == CNT_MAX) |-> r_total == CNT_MAX)
        else $error("saturated total changed");

    // Pick tables change only during a recompute
    a_pick_in_recomp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pick_wr.en |-> r_state == ST_RECOMP)
        else $error("pick write outside recompute");

    // No counter write-back while the scan owns the memory
    a_no_wb_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RECOMP |-> !mem_we)
        else $error("counter write during recompute");

    // A recompute item enters the scan
    a_recomp_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_start |=> r_state == ST_RECOMP)
        else $error("recompute item did not start the scan");

endmodule
